// File: rtl/core/ptd_pkg.sv
// ptd_pkg: shared types and codes for the palette texel decoder
// used by every module under rtl/core; depends on nothing
package ptd_pkg;

    // source colour formats (codes six and seven decode as 565)
    typedef enum logic [2:0] {
        FMT_555  = 3'd0,
        FMT_565  = 3'd1,
        FMT_1555 = 3'd2,
        FMT_4444 = 3'd3,
        FMT_888  = 3'd4,
        FMT_8888 = 3'd5
    } t_src_fmt;

    typedef enum logic [1:0] {
        DEPTH_IDX4  = 2'd0,
        DEPTH_IDX8  = 2'd1,
        DEPTH_DIR16 = 2'd2,
        DEPTH_DIR32 = 2'd3
    } t_depth;

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_TEXEL = 1'b1
    } t_func;

    typedef enum logic {
        CFG_SOURCE_FORMAT = 1'b0,
        CFG_TEXEL_DEPTH   = 1'b1
    } t_cfg_index;

    localparam logic [2:0] FORMAT_RESET = 3'd1;
    localparam logic [1:0] DEPTH_RESET  = 2'd2;
    localparam int         CFG_WIDTH    = 3;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // red in the low byte so the struct maps straight onto the output tdata
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgba;

    // control handed to the output stage when a texel transaction is taken
    typedef struct packed {
        logic valid;
        logic pair;
        logic direct;
    } t_launch;

endpackage

// File: rtl/core/ptd_convert.sv
// ptd_convert: 16/32-bit colour word to rgba8888 in the selected format
// depends on ptd_pkg
module ptd_convert (
    input  logic [2:0]    i_fmt,
    input  logic [31:0]   i_word,
    output ptd_pkg::t_rgba o_rgba
);

    ptd_pkg::t_rgba w_555;

    always_comb begin
        w_555.red   = {i_word[14:10], 3'b000};
        w_555.green = {i_word[9:5], 3'b000};
        w_555.blue  = {i_word[4:0], 3'b000};
        w_555.alpha = ptd_pkg::ALPHA_OPAQUE;
    end

    always_comb begin
        unique case (i_fmt) inside
            ptd_pkg::FMT_555: begin
                o_rgba = w_555;
            end
            ptd_pkg::FMT_1555, ptd_pkg::FMT_4444: begin
                if (i_word[15]) begin
                    o_rgba = w_555;
                end else begin
                    o_rgba.red   = {i_word[11:8], 4'b0000};
                    o_rgba.green = {i_word[7:4], 4'b0000};
                    o_rgba.blue  = {i_word[3:0], 4'b0000};
                    o_rgba.alpha = (i_fmt == ptd_pkg::FMT_4444) ?
                                   {i_word[14:12], 5'b00000} : 8'h00;
                end
            end
            ptd_pkg::FMT_888: begin
                o_rgba.red   = i_word[23:16];
                o_rgba.green = i_word[15:8];
                o_rgba.blue  = i_word[7:0];
                o_rgba.alpha = ptd_pkg::ALPHA_OPAQUE;
            end
            ptd_pkg::FMT_8888: begin
                o_rgba.red   = i_word[23:16];
                o_rgba.green = i_word[15:8];
                o_rgba.blue  = i_word[7:0];
                o_rgba.alpha = i_word[31:24];
            end
            default: begin
                // 565 and the unused codes
                o_rgba.red   = {i_word[15:11], 3'b000};
                o_rgba.green = {i_word[10:5], 2'b00};
                o_rgba.blue  = {i_word[4:0], 3'b000};
                o_rgba.alpha = ptd_pkg::ALPHA_OPAQUE;
            end
        endcase
    end

endmodule

// File: rtl/core/ptd_table.sv
// ptd_table: colour table, one write port and two registered read ports
// depends on ptd_pkg
module ptd_table #(
    parameter int ENTRIES = 256,
    parameter int AW      = 8
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  ptd_pkg::t_rgba i_wdata,
    input  logic           i_re,
    input  logic [AW-1:0]  i_raddr_hi,
    input  logic [AW-1:0]  i_raddr_lo,
    output ptd_pkg::t_rgba o_rdata_hi,
    output ptd_pkg::t_rgba o_rdata_lo
);

    ptd_pkg::t_rgba r_mem [ENTRIES];
    ptd_pkg::t_rgba r_rdata_hi;
    ptd_pkg::t_rgba r_rdata_lo;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while the output stage is stalled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_hi <= r_mem[i_raddr_hi];
            r_rdata_lo <= r_mem[i_raddr_lo];
        end
    end

    assign o_rdata_hi = r_rdata_hi;
    assign o_rdata_lo = r_rdata_lo;

endmodule

// File: rtl/core/ptd_out.sv
// ptd_out: output stage, emits one or two results per texel transaction
// depends on ptd_pkg; read data comes from ptd_table
module ptd_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ptd_pkg::t_launch i_launch,
    input  ptd_pkg::t_rgba   i_direct_rgba,
    input  ptd_pkg::t_rgba   i_rd_hi,
    input  ptd_pkg::t_rgba   i_rd_lo,
    input  logic             i_tready,
    output logic             o_tvalid,
    output ptd_pkg::t_rgba   o_tdata,
    output logic             o_tlast,
    output logic             o_free
);

    logic           r_valid;
    logic           r_pair;
    logic           r_phase;
    logic           r_direct;
    ptd_pkg::t_rgba r_rgba;

    logic           n_valid;
    logic           n_phase;
    logic           w_take;

    assign o_tvalid = r_valid;
    assign o_tlast  = !(r_pair && !r_phase);
    assign o_tdata  = r_direct ? r_rgba : (o_tlast ? i_rd_lo : i_rd_hi);
    assign w_take   = r_valid && i_tready;
    assign o_free   = !r_valid || (i_tready && o_tlast);

    always_comb begin
        n_valid = r_valid;
        n_phase = r_phase;
        if (w_take) begin
            if (o_tlast) begin
                n_valid = 1'b0;
                n_phase = 1'b0;
            end else begin
                n_phase = 1'b1;
            end
        end
        if (i_launch.valid) begin
            n_valid = 1'b1;
            n_phase = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
            r_pair  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
            if (i_launch.valid) begin
                r_pair <= i_launch.pair;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_launch.valid) begin
            r_direct <= i_launch.direct;
            r_rgba   <= i_direct_rgba;
        end
    end

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_launch.valid |-> (!r_valid || (i_tready && o_tlast)))
        else $error("texel launched while output stage still holds a result");

    a_pair_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_tready && !o_tlast) |=> (r_valid && o_tlast && !r_direct))
        else $error("second result of an index pair missing");

    a_phase_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_pair && r_valid))
        else $error("second phase without a pending pair");
`endif

endmodule

// File: rtl/core/palette_texel_decoder_core.sv
// palette_texel_decoder_core: top level of the palette texel decoder
// depends on ptd_pkg, ptd_convert, ptd_table, ptd_out
//
// usage
//   s_axis carries one item per transaction: tuser is the function
//   (load table entry or texel), tdata holds table_slot and source_word.
//   a load converts the low 16 bits of source_word in the current source
//   format and writes the colour table; it produces no result.
//   a texel gives one rgba8888 result on m_axis, or two for 4-bit indexed
//   texels (high nibble first); tlast marks the final result of an item.
//   the cfg port writes source_format (index 0) and texel_depth (index 1);
//   write it only while the block is idle; the block does not enforce this.
// timing: the first result appears in the cycle after the input transaction,
//   set by the registered table read; direct colour takes the same path.
// throughput: one item per cycle while m_axis is not stalled; a 4-bit indexed
//   texel holds off the next item, as the output moves one result per cycle.
// reset: synchronous, active low; clears the handshake state and loads
//   the register defaults (565, 16-bit direct). table contents are not
//   cleared and must be loaded before use.
// stall: m_axis holds its result; s_axis_tready stays high as long as
//   the final result in the output stage is taken in the same cycle.
module palette_texel_decoder_core #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [2:0]  i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // table_slot[7:0], source_word[39:8]
    input  logic        s_axis_tuser,   // func
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    output logic        m_axis_tlast
);

    localparam int AW = $clog2(TABLE_ENTRIES);

    // configuration registers
    logic [2:0] r_source_format;
    logic [1:0] r_texel_depth;

    // input fields
    logic [7:0]  w_slot;
    logic [31:0] w_word;
    logic        w_accept;
    logic        w_is_load;

    // datapath
    logic [31:0]      w_conv_word;
    ptd_pkg::t_rgba   w_conv_rgba;
    logic             w_we;
    logic             w_re;
    logic [AW-1:0]    w_raddr_hi;
    logic [AW-1:0]    w_raddr_lo;
    ptd_pkg::t_rgba   w_rd_hi;
    ptd_pkg::t_rgba   w_rd_lo;
    ptd_pkg::t_launch w_launch;
    ptd_pkg::t_rgba   w_out_rgba;
    logic             w_free;

    // 8-bit index modulo the table size by conditional subtraction of
    // shifted multiples; the index stays below sixteen times the size
    function automatic logic [AW-1:0] wrap_index(input logic [7:0] idx);
        logic [11:0] v;
        v = {4'b0000, idx};
        for (int k = 3; k >= 0; k--) begin
            if (v >= (12'(TABLE_ENTRIES) << k)) begin
                v = v - (12'(TABLE_ENTRIES) << k);
            end
        end
        return v[AW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_format <= ptd_pkg::FORMAT_RESET;
            r_texel_depth   <= ptd_pkg::DEPTH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ptd_pkg::CFG_SOURCE_FORMAT: r_source_format <= i_cfg_data;
                ptd_pkg::CFG_TEXEL_DEPTH:   r_texel_depth   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign w_slot    = s_axis_tdata[7:0];
    assign w_word    = s_axis_tdata[39:8];
    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_is_load = (s_axis_tuser == ptd_pkg::FUNC_LOAD);

    // palette words and 16-bit texels use only the low half
    assign w_conv_word = (w_is_load || r_texel_depth == ptd_pkg::DEPTH_DIR16) ?
                         {16'h0000, w_word[15:0]} : w_word;

    ptd_convert u_convert (
        .i_fmt  (r_source_format),
        .i_word (w_conv_word),
        .o_rgba (w_conv_rgba)
    );

    // loads beyond the table are dropped
    assign w_we = w_accept && w_is_load && ({1'b0, w_slot} < 9'(TABLE_ENTRIES));

    // a load and a texel never share a cycle, so a read always sees
    // every earlier load without forwarding
    assign w_re       = w_accept && !w_is_load && !r_texel_depth[1];
    assign w_raddr_hi = AW'(w_word[7:4]);
    assign w_raddr_lo = (r_texel_depth == ptd_pkg::DEPTH_IDX4) ?
                        AW'(w_word[3:0]) : wrap_index(w_word[7:0]);

    ptd_table #(
        .ENTRIES (TABLE_ENTRIES),
        .AW      (AW)
    ) u_table (
        .i_clk      (i_clk),
        .i_we       (w_we),
        .i_waddr    (w_slot[AW-1:0]),
        .i_wdata    (w_conv_rgba),
        .i_re       (w_re),
        .i_raddr_hi (w_raddr_hi),
        .i_raddr_lo (w_raddr_lo),
        .o_rdata_hi (w_rd_hi),
        .o_rdata_lo (w_rd_lo)
    );

    always_comb begin
        w_launch.valid  = w_accept && !w_is_load;
        w_launch.pair   = (r_texel_depth == ptd_pkg::DEPTH_IDX4);
        w_launch.direct = r_texel_depth[1];
    end

    ptd_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_launch      (w_launch),
        .i_direct_rgba (w_conv_rgba),
        .i_rd_hi       (w_rd_hi),
        .i_rd_lo       (w_rd_lo),
        .i_tready      (m_axis_tready),
        .o_tvalid      (m_axis_tvalid),
        .o_tdata       (w_out_rgba),
        .o_tlast       (m_axis_tlast),
        .o_free        (w_free)
    );

    assign s_axis_tready = w_free;
    assign m_axis_tdata  = w_out_rgba;

endmodule

// File: bench/tb_palette_texel_decoder_core.sv
// tb_palette_texel_decoder_core: self-checking bench for the palette texel decoder
// holds an rgba predictor class with its own colour table copy; depends on ptd_pkg and
// palette_texel_decoder_core
`timescale 1ns / 100ps

module tb_palette_texel_decoder_core;

    // one expected result; red sits in the top byte, the reverse of the result transaction
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } t_texel_out;

    // how the two stream sides pause during a phase
    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    // rgba predictor: mirrors the block's registers and colour table, queues
    // the results each accepted transaction should produce and matches them
    class texel_predictor;
        logic [31:0]      clut [256];   // red[31:24] green[23:16] blue[15:8] alpha[7:0]
        logic [2:0]       fmt;
        ptd_pkg::t_depth  depth;
        t_texel_out       pending_rgba [$];
        int               faults;

        function new();
            fmt    = ptd_pkg::FORMAT_RESET;
            depth  = ptd_pkg::t_depth'(ptd_pkg::DEPTH_RESET);
            faults = 0;
        endfunction

        // word to rgba8888 in the given source format
        function logic [31:0] expand(logic [2:0] f, logic [31:0] y);
            logic [31:0] rgb555;
            rgb555 = {y[14:10], 3'b0, y[9:5], 3'b0, y[4:0], 3'b0, ptd_pkg::ALPHA_OPAQUE};
            case (f) inside
                ptd_pkg::FMT_555: return rgb555;
                ptd_pkg::FMT_1555, ptd_pkg::FMT_4444: begin
                    // top bit set means opaque 555
                    if (y[15])
                        return rgb555;
                    return {y[11:8], 4'b0, y[7:4], 4'b0, y[3:0], 4'b0,
                            (f == ptd_pkg::FMT_4444) ? {y[14:12], 5'b0} : 8'h00};
                end
                ptd_pkg::FMT_888:  return {y[23:16], y[15:8], y[7:0], ptd_pkg::ALPHA_OPAQUE};
                ptd_pkg::FMT_8888: return {y[23:16], y[15:8], y[7:0], y[31:24]};
                default: return {y[15:11], 3'b0, y[10:5], 2'b0, y[4:0], 3'b0,
                                 ptd_pkg::ALPHA_OPAQUE};
            endcase
        endfunction

        function void push(logic [31:0] rgba, logic last);
            pending_rgba.push_back(t_texel_out'({rgba, last}));
        endfunction

        function void take_item(ptd_pkg::t_func f, logic [7:0] slot, logic [31:0] word);
            if (f == ptd_pkg::FUNC_LOAD) begin
                clut[slot] = expand(fmt, {16'h0, word[15:0]});
            end else begin
                case (depth)
                    ptd_pkg::DEPTH_IDX4: begin
                        push(clut[word[7:4]], 1'b0);
                        push(clut[word[3:0]], 1'b1);
                    end
                    ptd_pkg::DEPTH_IDX8:  push(clut[word[7:0]], 1'b1);
                    ptd_pkg::DEPTH_DIR16: push(expand(fmt, {16'h0, word[15:0]}), 1'b1);
                    default:              push(expand(fmt, word), 1'b1);
                endcase
            end
        endfunction

        function void match_result(logic [31:0] tdata, logic tlast);
            t_texel_out want;
            t_texel_out got;
            got = '{red: tdata[7:0], green: tdata[15:8], blue: tdata[23:16],
                    alpha: tdata[31:24], last: tlast};
            if (pending_rgba.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("%0t: unexpected result r=%h g=%h b=%h a=%h last=%b", $time,
                             got.red, got.green, got.blue, got.alpha, got.last);
            end else begin
                want = pending_rgba.pop_front();
                if (want.red !== got.red || want.green !== got.green ||
                    want.blue !== got.blue || want.alpha !== got.alpha ||
                    want.last !== got.last) begin
                    faults++;
                    if (faults <= 10)
                        $display("%0t: mismatch exp r=%h g=%h b=%h a=%h last=%b, ",
                                 $time, want.red, want.green, want.blue, want.alpha,
                                 want.last,
                                 "got r=%h g=%h b=%h a=%h last=%b",
                                 got.red, got.green, got.blue, got.alpha, got.last);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [2:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;    // table_slot[7:0], source_word[39:8]
    logic        s_axis_tuser;    // func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;    // red[7:0], green[15:8], blue[23:16], alpha[31:24]
    logic        m_axis_tlast;

    texel_predictor pred;
    int unsigned    gap_pct;      // chance per cycle that the sender holds off
    int unsigned    stall_pct;    // chance per cycle that the receiver stalls

    palette_texel_decoder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // receiver side: random backpressure at the rate of the current phase
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // result monitor: values read here are the ones in force before this edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            pred.match_result(m_axis_tdata, m_axis_tlast);
    end

    // hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function void set_idle(t_idle_mode mode);
        case (mode)
            IDLE_SENDER:   begin gap_pct = 85; stall_pct = 0;  end
            IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 85; end
            IDLE_BOTH:     begin gap_pct = 6;  stall_pct = 6;  end
            default:       begin gap_pct = 0;  stall_pct = 0;  end
        endcase
    endfunction

    // writes both registers on back-to-back edges, block must be idle
    task automatic set_config(input logic [2:0] fmt, input ptd_pkg::t_depth depth);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= ptd_pkg::CFG_SOURCE_FORMAT;
        i_cfg_data  <= fmt;
        @(posedge i_clk);
        pred.fmt = fmt;
        i_cfg_index <= ptd_pkg::CFG_TEXEL_DEPTH;
        i_cfg_data  <= {1'b0, depth};
        @(posedge i_clk);
        pred.depth = depth;
        i_cfg_we <= 1'b0;
    endtask

    // one input transaction; valid stays high into the next call unless a gap is drawn
    task automatic send_item(input ptd_pkg::t_func f, input logic [7:0] slot,
                             input logic [31:0] word);
        if ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < gap_pct)
                @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= {word, slot};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        pred.take_item(f, slot, word);
    endtask

    // drain: wait for all expected results, then let a trailing table load complete
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pred.pending_rgba.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        logic [2:0] fmt;

        pred          = new();
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= ptd_pkg::CFG_SOURCE_FORMAT;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ptd_pkg::FUNC_LOAD;
        set_idle(IDLE_NONE);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset defaults are 565 and 16-bit direct
        send_item(ptd_pkg::FUNC_TEXEL, 8'h00, 32'h0000_0000);
        send_item(ptd_pkg::FUNC_TEXEL, 8'hFF, 32'hFFFF_FFFF);   // upper half must be ignored
        send_item(ptd_pkg::FUNC_TEXEL, 8'h00, 32'h0000_F81F);
        send_item(ptd_pkg::FUNC_LOAD,  8'h00, 32'hABCD_FFFF);   // palette takes low 16 bits
        send_item(ptd_pkg::FUNC_LOAD,  8'hFF, 32'h0000_0000);
        settle();

        // 1555 palette, opaque and transparent entries, 8-bit indices
        set_config(ptd_pkg::FMT_1555, ptd_pkg::DEPTH_IDX8);
        send_item(ptd_pkg::FUNC_LOAD,  8'h01, 32'h0000_FC1F);
        send_item(ptd_pkg::FUNC_LOAD,  8'h02, 32'h0000_7FFF);
        send_item(ptd_pkg::FUNC_TEXEL, 8'h00, 32'hFFFF_FF00);   // index is only the low byte
        send_item(ptd_pkg::FUNC_TEXEL, 8'h00, 32'h0000_00FF);
        send_item(ptd_pkg::FUNC_TEXEL, 8'h00, 32'h0000_0001);
        send_item(ptd_pkg::FUNC_TEXEL, 8'h00, 32'h0000_0002);
        settle();

        // 4444 with alpha bits, 4-bit index pairs, high nibble first
        set_config(ptd_pkg::FMT_4444, ptd_pkg::DEPTH_IDX4);
        send_item(ptd_pkg::FUNC_LOAD,  8'h03, 32'h0000_7ABC);
        send_item(ptd_pkg::FUNC_LOAD,  8'h04, 32'h0000_8421);
        send_item(ptd_pkg::FUNC_TEXEL, 8'h00, 32'h0000_0034);
        send_item(ptd_pkg::FUNC_TEXEL, 8'h00, 32'hFFFF_FF12);
        send_item(ptd_pkg::FUNC_TEXEL, 8'h00, 32'h0000_0000);
        settle();

        // 888: palette load loses red, direct 32-bit keeps it
        set_config(ptd_pkg::FMT_888, ptd_pkg::DEPTH_DIR32);
        send_item(ptd_pkg::FUNC_LOAD,  8'h05, 32'h1234_5678);
        send_item(ptd_pkg::FUNC_TEXEL, 8'h00, 32'hFFFF_FFFF);
        send_item(ptd_pkg::FUNC_TEXEL, 8'h00, 32'h0012_3456);
        settle();

        // 8888: alpha from the top byte, palette loads get zero alpha
        set_config(ptd_pkg::FMT_8888, ptd_pkg::DEPTH_DIR32);
        send_item(ptd_pkg::FUNC_LOAD,  8'h06, 32'hFFFF_FFFF);
        send_item(ptd_pkg::FUNC_TEXEL, 8'h00, 32'h8040_2010);
        send_item(ptd_pkg::FUNC_TEXEL, 8'h00, 32'hFFFF_FFFF);
        settle();

        // entries keep the format they were loaded with
        set_config(ptd_pkg::FMT_555, ptd_pkg::DEPTH_IDX8);
        send_item(ptd_pkg::FUNC_TEXEL, 8'h00, 32'h0000_0005);
        send_item(ptd_pkg::FUNC_TEXEL, 8'h00, 32'h0000_0006);
        settle();

        // unknown format code decodes as 565
        set_config(3'd7, ptd_pkg::DEPTH_DIR16);
        send_item(ptd_pkg::FUNC_TEXEL, 8'h00, 32'hFFFF_F81F);
        settle();

        // fill the whole table so any later index reads a loaded entry
        for (int c = 0; c < 4; c++) begin
            set_config(3'($urandom_range(7)), pred.depth);
            set_idle(t_idle_mode'(c));
            for (int s = 0; s < 64; s++)
                send_item(ptd_pkg::FUNC_LOAD, 8'(c * 64 + s), $urandom);
            settle();
        end

        // random phases: every depth meets every idle mode, all format codes
        for (int p = 0; p < 16; p++) begin
            fmt = (p < 8) ? p[2:0] : 3'($urandom_range(7));
            set_config(fmt, ptd_pkg::t_depth'((p + p / 4) % 4));
            set_idle(t_idle_mode'(p % 4));
            repeat (85) begin
                if ($urandom_range(3) == 0)
                    send_item(ptd_pkg::FUNC_LOAD, 8'($urandom), $urandom);
                else
                    send_item(ptd_pkg::FUNC_TEXEL, 8'($urandom), $urandom);
            end
            settle();
        end

        repeat (10) @(posedge i_clk);
        if (pred.faults == 0 && pred.pending_rgba.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
